@@ rtl/dup_pkg.sv @@
package dup_pkg;

  localparam int PAYLOAD_CAP_DEF   = 512;
  localparam int POSITION_BITS_DEF = 16;
  localparam int LEN_BITS          = 16;
  localparam int QUEUE_DEPTH       = 2;

  localparam logic [15:0] ETH_IPV4       = 16'h0800;
  localparam logic [15:0] ETH_IPV6       = 16'h86DD;
  localparam logic [15:0] DNS_PORT_RESET = 16'd53;
  localparam logic [15:0] ETH_LEN        = 16'd14;
  localparam logic [15:0] UDP_HDR        = 16'd8;
  localparam logic [7:0]  PROTO_UDP      = 8'd17;
  localparam logic [3:0]  IHL_MIN        = 4'd5;
  localparam logic [6:0]  OFF_V6         = 7'd62;
  localparam logic [6:0]  OFF_V4_BASE    = 7'd22;

  typedef enum logic [2:0] {
    ACT_NONE,
    ACT_PROTO,
    ACT_SRC_HI,
    ACT_SRC_LO,
    ACT_DST_HI,
    ACT_DST_LO,
    ACT_PORTS,
    ACT_ULEN
  } act_t;

  // one classified byte, frame summary is meaningful on the last beat only
  typedef struct packed {
    logic [7:0]          data;
    logic                last;
    act_t                act;
    logic [2:0]          lane;
    logic                is_v4;
    logic                is_v6;
    logic                reject;
    logic [3:0]          ihl;
    logic [LEN_BITS-1:0] frame_len;
  } entry_t;

  typedef struct packed {
    logic        accepted;
    logic        is_ipv6;
    logic [63:0] src_hi;
    logic [63:0] src_lo;
    logic [63:0] dst_hi;
    logic [63:0] dst_lo;
    logic [15:0] sport;
    logic [15:0] dport;
    logic [9:0]  dns_length;
    logic        is_query;
    logic [6:0]  payload_offset;
    logic        payload_present;
  } result_t;

endpackage

@@ rtl/dup_fifo.sv @@
module dup_fifo import dup_pkg::*; #(
  parameter int WIDTH = 8,
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_valid,
  output logic             wr_ready,
  input  logic [WIDTH-1:0] wr_data,
  output logic             rd_valid,
  input  logic             rd_ready,
  output logic [WIDTH-1:0] rd_data
);

  localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_BITS = $clog2(DEPTH + 1);
  localparam logic [PTR_BITS-1:0] PTR_LAST = PTR_BITS'(DEPTH - 1);
  localparam logic [CNT_BITS-1:0] CNT_FULL = CNT_BITS'(DEPTH);

  logic [WIDTH-1:0]    mem [DEPTH];
  logic [PTR_BITS-1:0] wr_ptr;
  logic [PTR_BITS-1:0] rd_ptr;
  logic [CNT_BITS-1:0] count;
  logic                push;
  logic                pop;

  assign wr_ready = (count != CNT_FULL);
  assign rd_valid = (count != '0);
  assign rd_data  = mem[rd_ptr];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + 1'b1;
      end
      unique case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

@@ rtl/dup_front.sv @@
module dup_front import dup_pkg::*; #(
  parameter int POSITION_BITS = POSITION_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] frame_byte,
  input  logic       last_byte,
  output logic       q_valid,
  input  logic       q_ready,
  output entry_t     q_entry
);

  localparam logic [POSITION_BITS-1:0] POS_MAX = '1;

  logic [POSITION_BITS-1:0] pos;
  logic [POSITION_BITS-1:0] pos_next;
  logic [15:0]              ether_type;
  logic [15:0]              ether_type_next;
  logic [3:0]               ihl;
  logic [3:0]               ihl_next;
  logic                     reject;
  logic                     reject_next;
  logic [LEN_BITS-1:0]      p;
  logic [LEN_BITS-1:0]      udp_k;
  logic                     take;
  logic                     accept;
  act_t                     act;
  logic [2:0]               lane;

  assign in_ready = q_ready;
  assign q_valid  = in_valid;
  assign accept   = in_valid && q_ready;

  always_comb begin
    p               = LEN_BITS'(pos);
    take            = (pos != POS_MAX);
    pos_next        = take ? pos + 1'b1 : pos;
    ether_type_next = ether_type;
    ihl_next        = ihl;
    reject_next     = reject;
    act             = ACT_NONE;
    lane            = '0;
    // offset inside the udp header, wraps high when before it
    udp_k           = p - (ETH_LEN + {10'd0, ihl, 2'b00});
    if (take) begin
      if (p == 16'd12 || p == 16'd13) begin
        ether_type_next = {ether_type[7:0], frame_byte};
      end else if (ether_type == ETH_IPV4) begin
        if (p == 16'd14) begin
          ihl_next = frame_byte[3:0];
          if (frame_byte[3:0] < IHL_MIN) begin
            reject_next = 1'b1;
          end
        end else if (p == 16'd23) begin
          act = ACT_PROTO;
        end else if (p >= 16'd26 && p < 16'd30) begin
          act  = ACT_SRC_LO;
          lane = 3'(16'd29 - p);
        end else if (p >= 16'd30 && p < 16'd34) begin
          act  = ACT_DST_LO;
          lane = 3'(16'd33 - p);
        end
        if (p > 16'd14 && !reject && udp_k < UDP_HDR) begin
          if (udp_k < 16'd4) begin
            act  = ACT_PORTS;
            lane = 3'(16'd3 - udp_k);
          end else if (udp_k < 16'd6) begin
            act  = ACT_ULEN;
            lane = 3'(16'd5 - udp_k);
          end
        end
      end else if (ether_type == ETH_IPV6) begin
        if (p == 16'd20) begin
          act = ACT_PROTO;
        end else if (p >= 16'd22 && p < 16'd30) begin
          act  = ACT_SRC_HI;
          lane = 3'(16'd29 - p);
        end else if (p >= 16'd30 && p < 16'd38) begin
          act  = ACT_SRC_LO;
          lane = 3'(16'd37 - p);
        end else if (p >= 16'd38 && p < 16'd46) begin
          act  = ACT_DST_HI;
          lane = 3'(16'd45 - p);
        end else if (p >= 16'd46 && p < 16'd54) begin
          act  = ACT_DST_LO;
          lane = 3'(16'd53 - p);
        end else if (p >= 16'd54 && p < 16'd58) begin
          act  = ACT_PORTS;
          lane = 3'(16'd57 - p);
        end else if (p >= 16'd58 && p < 16'd60) begin
          act  = ACT_ULEN;
          lane = 3'(16'd59 - p);
        end
      end
    end

    q_entry.data      = frame_byte;
    q_entry.last      = last_byte;
    q_entry.act       = act;
    q_entry.lane      = lane;
    q_entry.is_v4     = (ether_type_next == ETH_IPV4);
    q_entry.is_v6     = (ether_type_next == ETH_IPV6);
    q_entry.reject    = reject_next;
    q_entry.ihl       = ihl_next;
    q_entry.frame_len = LEN_BITS'(pos_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos        <= '0;
      ether_type <= '0;
      ihl        <= '0;
      reject     <= 1'b0;
    end else if (accept) begin
      if (last_byte) begin
        pos        <= '0;
        ether_type <= '0;
        ihl        <= '0;
        reject     <= 1'b0;
      end else begin
        pos        <= pos_next;
        ether_type <= ether_type_next;
        ihl        <= ihl_next;
        reject     <= reject_next;
      end
    end
  end

endmodule

@@ rtl/dup_back.sv @@
module dup_back import dup_pkg::*; #(
  parameter int PAYLOAD_CAP = PAYLOAD_CAP_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        q_valid,
  output logic        q_ready,
  input  entry_t      q_entry,
  input  logic [15:0] dns_port,
  output logic        out_valid,
  input  logic        out_ready,
  output result_t     res
);

  localparam int DLEN_BITS = $clog2(PAYLOAD_CAP + 1);
  localparam logic [15:0]          CAP16 = 16'(PAYLOAD_CAP);
  localparam logic [DLEN_BITS-1:0] CAP_D = DLEN_BITS'(PAYLOAD_CAP);

  logic [7:0]           proto, proto_next;
  logic [63:0]          src_hi, src_hi_next;
  logic [63:0]          src_lo, src_lo_next;
  logic [63:0]          dst_hi, dst_hi_next;
  logic [63:0]          dst_lo, dst_lo_next;
  logic [31:0]          ports, ports_next;
  logic [15:0]          ulen, ulen_next;
  logic [15:0]          sport;
  logic [15:0]          dport;
  logic [15:0]          dlen_raw;
  logic [DLEN_BITS-1:0] dlen;
  logic [6:0]           off;
  logic                 ok;
  logic                 pop;
  result_t              res_next;

  assign q_ready = !q_entry.last || !out_valid || out_ready;
  assign pop     = q_valid && q_ready;

  // merge this beat into the header fields
  always_comb begin
    proto_next  = proto;
    src_hi_next = src_hi;
    src_lo_next = src_lo;
    dst_hi_next = dst_hi;
    dst_lo_next = dst_lo;
    ports_next  = ports;
    ulen_next   = ulen;
    unique case (q_entry.act)
      ACT_NONE:   ;
      ACT_PROTO:  proto_next = q_entry.data;
      ACT_SRC_HI: src_hi_next[{q_entry.lane, 3'b000} +: 8] = q_entry.data;
      ACT_SRC_LO: src_lo_next[{q_entry.lane, 3'b000} +: 8] = q_entry.data;
      ACT_DST_HI: dst_hi_next[{q_entry.lane, 3'b000} +: 8] = q_entry.data;
      ACT_DST_LO: dst_lo_next[{q_entry.lane, 3'b000} +: 8] = q_entry.data;
      ACT_PORTS:  ports_next[{q_entry.lane[1:0], 3'b000} +: 8] = q_entry.data;
      ACT_ULEN:   ulen_next[{q_entry.lane[0], 3'b000} +: 8] = q_entry.data;
      default:    ;
    endcase
  end

  always_comb begin
    sport    = ports_next[31:16];
    dport    = ports_next[15:0];
    off      = q_entry.is_v6 ? OFF_V6 : OFF_V4_BASE + {1'b0, q_entry.ihl, 2'b00};
    // underflow wraps high and so lands on the cap as well
    dlen_raw = ulen_next - UDP_HDR;
    dlen     = (dlen_raw > CAP16) ? CAP_D : dlen_raw[DLEN_BITS-1:0];
    ok       = (q_entry.frame_len >= ETH_LEN)
            && (q_entry.is_v4 || q_entry.is_v6)
            && !(q_entry.is_v4 && q_entry.reject)
            && (q_entry.frame_len >= LEN_BITS'(off))
            && (proto_next == PROTO_UDP)
            && (sport == dns_port || dport == dns_port);
    res_next = '0;
    if (ok) begin
      res_next.accepted        = 1'b1;
      res_next.is_ipv6         = q_entry.is_v6;
      res_next.src_hi          = src_hi_next;
      res_next.src_lo          = src_lo_next;
      res_next.dst_hi          = dst_hi_next;
      res_next.dst_lo          = dst_lo_next;
      res_next.sport           = sport;
      res_next.dport           = dport;
      res_next.dns_length      = 10'(dlen);
      res_next.is_query        = (dport == dns_port);
      res_next.payload_offset  = off;
      res_next.payload_present = (dlen != '0)
        && ((17'(off) + 17'(dlen)) <= 17'(q_entry.frame_len));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      proto  <= '0;
      src_hi <= '0;
      src_lo <= '0;
      dst_hi <= '0;
      dst_lo <= '0;
      ports  <= '0;
      ulen   <= '0;
    end else if (pop) begin
      if (q_entry.last) begin
        proto  <= '0;
        src_hi <= '0;
        src_lo <= '0;
        dst_hi <= '0;
        dst_lo <= '0;
        ports  <= '0;
        ulen   <= '0;
      end else begin
        proto  <= proto_next;
        src_hi <= src_hi_next;
        src_lo <= src_lo_next;
        dst_hi <= dst_hi_next;
        dst_lo <= dst_lo_next;
        ports  <= ports_next;
        ulen   <= ulen_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop && q_entry.last) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && q_entry.last) begin
      res <= res_next;
    end
  end

endmodule

@@ rtl/dns_udp_header_parser.sv @@
// channel  | handshake             | payload
// ---------+-----------------------+-------------------------------------------
// in       | in_valid / in_ready   | frame_byte, last_byte
// out      | out_valid / out_ready | accepted .. payload_present (one per frame)
// cfg      | cfg_valid / cfg_ready | dns_port
//
// one byte per cycle sustained unless the back is stalled; the front classifies a
// byte at its accept edge and writes it into a two-entry queue; the back merges it
// when it pops it, and the result is registered when the back pops the last byte.
// synchronous reset clears the frame state, the queue and out_valid; dns port 53.
// a result held by out_ready low stalls the back on the next last beat only,
// the front keeps taking bytes until the queue is full.
module dns_udp_header_parser import dup_pkg::*; #(
  parameter int PAYLOAD_CAP   = PAYLOAD_CAP_DEF,
  parameter int POSITION_BITS = POSITION_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  frame_byte,
  input  logic        last_byte,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] dns_port,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        accepted,
  output logic        is_ipv6,
  output logic [63:0] source_addr_high,
  output logic [63:0] source_addr_low,
  output logic [63:0] dest_addr_high,
  output logic [63:0] dest_addr_low,
  output logic [15:0] source_port,
  output logic [15:0] dest_port,
  output logic [9:0]  dns_length,
  output logic        is_query,
  output logic [6:0]  payload_offset,
  output logic        payload_present
);

  logic [15:0] port_cfg;
  logic        fq_valid;
  logic        fq_ready;
  entry_t      fq_entry;
  logic        bq_valid;
  logic        bq_ready;
  entry_t      bq_entry;
  result_t     res;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      port_cfg <= DNS_PORT_RESET;
    end else if (cfg_valid) begin
      port_cfg <= dns_port;
    end
  end

  dup_front #(
    .POSITION_BITS(POSITION_BITS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .frame_byte(frame_byte),
    .last_byte (last_byte),
    .q_valid   (fq_valid),
    .q_ready   (fq_ready),
    .q_entry   (fq_entry)
  );

  dup_fifo #(
    .WIDTH($bits(entry_t)),
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_valid(fq_valid),
    .wr_ready(fq_ready),
    .wr_data (fq_entry),
    .rd_valid(bq_valid),
    .rd_ready(bq_ready),
    .rd_data (bq_entry)
  );

  dup_back #(
    .PAYLOAD_CAP(PAYLOAD_CAP)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (bq_valid),
    .q_ready  (bq_ready),
    .q_entry  (bq_entry),
    .dns_port (port_cfg),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .res      (res)
  );

  assign accepted         = res.accepted;
  assign is_ipv6          = res.is_ipv6;
  assign source_addr_high = res.src_hi;
  assign source_addr_low  = res.src_lo;
  assign dest_addr_high   = res.dst_hi;
  assign dest_addr_low    = res.dst_lo;
  assign source_port      = res.sport;
  assign dest_port        = res.dport;
  assign dns_length       = res.dns_length;
  assign is_query         = res.is_query;
  assign payload_offset   = res.payload_offset;
  assign payload_present  = res.payload_present;

  a_reject_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !accepted |-> source_port == 16'd0 && dest_port == 16'd0
      && dns_length == 10'd0 && payload_offset == 7'd0 && !payload_present
      && !is_query && !is_ipv6)
    else $error("rejected frame carries nonzero fields");

  a_offset_range: assert property (@(posedge clk) disable iff (rst)
    out_valid && accepted |-> payload_offset >= 7'd42 && payload_offset <= 7'd82)
    else $error("payload offset out of range");

  a_v4_addr: assert property (@(posedge clk) disable iff (rst)
    out_valid && accepted && !is_ipv6 |-> source_addr_high == 64'd0
      && dest_addr_high == 64'd0 && source_addr_low[63:32] == 32'd0
      && dest_addr_low[63:32] == 32'd0)
    else $error("ipv4 result with upper address bits");

  a_port_match: assert property (@(posedge clk) disable iff (rst)
    out_valid && accepted |-> (source_port == port_cfg || dest_port == port_cfg)
      && (is_query == (dest_port == port_cfg)))
    else $error("accepted frame does not match the dns port");

endmodule
